>>> hw/rtl/pllm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the pooled linked list manager.
// Depends on nothing; every other file of the block imports it.
package pllm_pkg;

    localparam int SEL_W  = 4;
    localparam int FUNC_W = 4;
    localparam int CNT_W  = 7;
    localparam int DATA_W = 32;

    // Command codes.
    localparam logic [FUNC_W-1:0] F_CREATE     = 4'd0;
    localparam logic [FUNC_W-1:0] F_COUNT      = 4'd1;
    localparam logic [FUNC_W-1:0] F_FIRST      = 4'd2;
    localparam logic [FUNC_W-1:0] F_LAST       = 4'd3;
    localparam logic [FUNC_W-1:0] F_NEXT       = 4'd4;
    localparam logic [FUNC_W-1:0] F_PREV       = 4'd5;
    localparam logic [FUNC_W-1:0] F_CURRENT    = 4'd6;
    localparam logic [FUNC_W-1:0] F_INS_AFTER  = 4'd7;
    localparam logic [FUNC_W-1:0] F_INS_BEFORE = 4'd8;
    localparam logic [FUNC_W-1:0] F_APPEND     = 4'd9;
    localparam logic [FUNC_W-1:0] F_PREPEND    = 4'd10;
    localparam logic [FUNC_W-1:0] F_REMOVE     = 4'd11;
    localparam logic [FUNC_W-1:0] F_TRIM       = 4'd12;
    localparam logic [FUNC_W-1:0] F_CONCAT     = 4'd13;
    localparam logic [FUNC_W-1:0] F_FREE       = 4'd14;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SEL_W-1:0]  list_sel;
        logic [SEL_W-1:0]  other_list;
        logic [DATA_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] item_out;
        logic              item_present;
        logic              status;
        logic [SEL_W-1:0]  new_list;
        logic [CNT_W-1:0]  count_out;
        logic              last_of_run;
    } t_out_item;

    // Step strobes from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic head;
        logic link;
        logic item;
        logic ins1;
        logic ins2;
        logic rem;
        logic trim;
        logic cat;
        logic fread;
        logic femit;
        logic wb;
        logic resp;
    } t_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              bad;
        logic              empty;
        logic              cur_valid;
        logic              at_edge;
        logic              node_full;
        logic              cat_bad;
        logic              free_last;
        logic              out_free;
    } t_stat;

endpackage

>>> hw/rtl/pllm_in_if.sv
`timescale 1ns / 1ps
// Command channel of the pooled linked list manager.
// Depends on pllm_pkg for field widths.
interface pllm_in_if;
    import pllm_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SEL_W-1:0]  list_sel;
    logic [SEL_W-1:0]  other_list;
    logic [DATA_W-1:0] item_value;

    modport source (output valid, func, list_sel, other_list, item_value, input ready);
    modport sink   (input valid, func, list_sel, other_list, item_value, output ready);
endinterface

>>> hw/rtl/pllm_out_if.sv
`timescale 1ns / 1ps
// Result channel of the pooled linked list manager.
// Depends on pllm_pkg for field widths.
interface pllm_out_if;
    import pllm_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] item_out;
    logic              item_present;
    logic              status;
    logic [SEL_W-1:0]  new_list;
    logic [CNT_W-1:0]  count_out;
    logic              last_of_run;

    modport source (output valid, item_out, item_present, status, new_list, count_out,
                    last_of_run, input ready);
    modport sink   (input valid, item_out, item_present, status, new_list, count_out,
                    last_of_run, output ready);
endinterface

>>> hw/rtl/pllm_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the pooled linked list manager.
// Depends on pllm_pkg for the command and status structs.
module pllm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pllm_pkg::t_stat i_stat,
    output pllm_pkg::t_cmd  o_cmd
);
    import pllm_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_HEAD  = 13'b0000000000010,
        S_LINK  = 13'b0000000000100,
        S_ITEM  = 13'b0000000001000,
        S_INS1  = 13'b0000000010000,
        S_INS2  = 13'b0000000100000,
        S_REM   = 13'b0000001000000,
        S_TRIM  = 13'b0000010000000,
        S_CAT   = 13'b0000100000000,
        S_FREAD = 13'b0001000000000,
        S_FEMIT = 13'b0010000000000,
        S_WB    = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    // Next state and step strobes.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_HEAD;
            end
            S_HEAD: begin
                o_cmd.head = 1'b1;
                n_state    = S_RESP;
                if (i_stat.func != F_CREATE && !i_stat.bad) begin
                    case (i_stat.func)
                        F_FIRST, F_LAST: begin
                            if (!i_stat.empty) n_state = S_ITEM;
                        end
                        F_NEXT, F_PREV: begin
                            if (i_stat.cur_valid && !i_stat.at_edge) n_state = S_LINK;
                        end
                        F_CURRENT: begin
                            if (i_stat.cur_valid) n_state = S_ITEM;
                        end
                        F_INS_AFTER, F_INS_BEFORE, F_APPEND, F_PREPEND: begin
                            if (!i_stat.node_full) n_state = i_stat.empty ? S_WB : S_INS1;
                        end
                        F_REMOVE: begin
                            if (i_stat.cur_valid) n_state = S_REM;
                        end
                        F_TRIM: begin
                            if (!i_stat.empty) n_state = S_TRIM;
                        end
                        F_CONCAT: begin
                            if (!i_stat.cat_bad) n_state = S_CAT;
                        end
                        F_FREE: begin
                            n_state = i_stat.empty ? S_FEMIT : S_FREAD;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_ITEM;
            end
            S_ITEM: begin
                o_cmd.item = 1'b1;
                n_state    = S_WB;
            end
            S_INS1: begin
                o_cmd.ins1 = 1'b1;
                n_state    = S_INS2;
            end
            S_INS2: begin
                o_cmd.ins2 = 1'b1;
                n_state    = S_WB;
            end
            S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = S_WB;
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_WB;
            end
            S_CAT: begin
                o_cmd.cat = 1'b1;
                n_state   = S_WB;
            end
            S_FREAD: begin
                o_cmd.fread = 1'b1;
                n_state     = S_FEMIT;
            end
            S_FEMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.femit = 1'b1;
                    n_state = (i_stat.empty || i_stat.free_last) ? S_IDLE : S_FREAD;
                end
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/pllm_dpath.sv
`timescale 1ns / 1ps
// Datapath of the pooled linked list manager: node and head memories, free chains,
// cursor flags, working registers and the result register. Depends on pllm_pkg.
module pllm_dpath #(
    parameter int NODE_COUNT = 64,
    parameter int HEAD_COUNT = 16,
    parameter int ITEM_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pllm_pkg::t_cmd      i_cmd,
    output pllm_pkg::t_stat     o_stat,
    input  pllm_pkg::t_in_item  i_in_item,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output pllm_pkg::t_out_item o_out_item
);
    import pllm_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = (HEAD_COUNT > 1) ? $clog2(HEAD_COUNT) : 1;
    localparam int SW = (ITEM_WIDTH < DATA_W) ? ITEM_WIDTH : DATA_W;

    // Memories.
    logic [SW-1:0]    m_item  [NODE_COUNT];
    logic [NW-1:0]    m_next  [NODE_COUNT];
    logic [NW-1:0]    m_prev  [NODE_COUNT];
    logic [NW-1:0]    m_flink [NODE_COUNT];
    logic [NW-1:0]    m_first [HEAD_COUNT];
    logic [NW-1:0]    m_last  [HEAD_COUNT];
    logic [NW-1:0]    m_cur   [HEAD_COUNT];
    logic [CNT_W-1:0] m_size  [HEAD_COUNT];
    logic [LW-1:0]    m_lfl   [HEAD_COUNT];

    // Registered read data.
    logic [SW-1:0]    r_rd_item;
    logic [NW-1:0]    r_rd_next, r_rd_prev, r_rd_flink;
    logic [NW-1:0]    r_rd_first, r_rd_last, r_rd_cur;
    logic [CNT_W-1:0] r_rd_size;
    logic [LW-1:0]    r_rd_lfl;

    // Memory port controls.
    logic             it_we, it_re, nx_we, nx_re, pv_we, pv_re, fl_we, fl_re;
    logic [NW-1:0]    it_wa, it_ra, nx_wa, nx_ra, pv_wa, pv_ra, fl_wa;
    logic [SW-1:0]    it_wd;
    logic [NW-1:0]    nx_wd, pv_wd, fl_wd;
    logic             hd_re, hd_we, sz_we, lf_we, lf_re;
    logic [LW-1:0]    hd_ra, hd_wa, sz_wa, lf_wa;
    logic [CNT_W-1:0] sz_wd;
    logic [LW-1:0]    lf_wd;

    // Control registers.
    logic [NODE_COUNT-1:0] r_node_used, n_node_used, r_nfl_wr, n_nfl_wr;
    logic [HEAD_COUNT-1:0] r_list_used, n_list_used, r_cv, n_cv, r_pe, n_pe;
    logic [HEAD_COUNT-1:0] r_lfl_wr, n_lfl_wr;
    logic [NW-1:0]         r_fnt, n_fnt;
    logic [LW-1:0]         r_flt, n_flt;
    logic                  r_out_valid, n_out_valid;

    // Working registers.
    logic [FUNC_W-1:0] r_func, n_func;
    logic [SEL_W-1:0]  r_l, n_l, r_ol, n_ol;
    logic [SW-1:0]     r_val, n_val;
    logic              r_fl_wr, n_fl_wr, r_lf_wr, n_lf_wr;
    logic [NW-1:0]     r_hf, n_hf, r_hl, n_hl, r_hc, n_hc;
    logic [CNT_W-1:0]  r_hs, n_hs, r_k, n_k;
    logic [NW-1:0]     r_n, n_n, r_nb, n_nb, r_ceff, n_ceff;
    logic              r_after, n_after, r_cend, n_cend;
    logic [SW-1:0]     r_res_item, n_res_item;
    logic              r_res_present, n_res_present, r_res_status, n_res_status;
    logic [SEL_W-1:0]  r_res_new, n_res_new;
    t_out_item         r_out, n_out;

    // Derived values.
    logic [LW-1:0]    w_li, w_oi;
    logic             w_l_ok, w_o_ok, w_cv, w_pe;
    logic [NW-1:0]    w_hf, w_hl, w_hc, w_next_free;
    logic [CNT_W-1:0] w_hs;
    logic [LW-1:0]    w_next_list;
    logic             w_bad, w_out_free;

    assign w_li   = LW'(r_l);
    assign w_oi   = LW'(r_ol);
    assign w_l_ok = (32'(r_l) < HEAD_COUNT);
    assign w_o_ok = (32'(r_ol) < HEAD_COUNT);
    assign w_cv   = r_cv[w_li];
    assign w_pe   = r_pe[w_li];
    // During the head step the head fields come straight from the memory read registers.
    assign w_hf   = i_cmd.head ? r_rd_first : r_hf;
    assign w_hl   = i_cmd.head ? r_rd_last  : r_hl;
    assign w_hc   = i_cmd.head ? r_rd_cur   : r_hc;
    assign w_hs   = i_cmd.head ? r_rd_size  : r_hs;
    assign w_bad  = (r_func > F_FREE) || !w_l_ok || !r_list_used[w_li];
    assign w_out_free = !r_out_valid || i_out_ready;

    // A free link that was never written reads as index plus one, wrapping.
    assign w_next_free = r_fl_wr ? r_rd_flink :
                         ((r_fnt == NW'(NODE_COUNT - 1)) ? '0 : r_fnt + 1'b1);
    assign w_next_list = r_lf_wr ? r_rd_lfl :
                         ((r_flt == LW'(HEAD_COUNT - 1)) ? '0 : r_flt + 1'b1);

    // Status to the controller.
    always_comb begin
        o_stat.func      = r_func;
        o_stat.bad       = w_bad;
        o_stat.empty     = (w_hs == '0);
        o_stat.cur_valid = w_cv;
        o_stat.at_edge   = (r_func == F_NEXT) ? (w_hc == w_hl) : (w_hc == w_hf);
        o_stat.node_full = r_node_used[r_fnt];
        o_stat.cat_bad   = !w_o_ok || (r_ol == r_l) || !r_list_used[w_oi];
        o_stat.free_last = (CNT_W'(r_k + 1'b1) == r_hs);
        o_stat.out_free  = w_out_free;
    end

    // Step actions.
    always_comb begin
        logic          v_after;
        logic [NW-1:0] v_c;
        logic [NW-1:0] v_nb;

        v_after = 1'b0;
        v_c     = '0;
        v_nb    = '0;

        n_node_used = r_node_used;  n_nfl_wr = r_nfl_wr;
        n_list_used = r_list_used;  n_cv = r_cv;  n_pe = r_pe;  n_lfl_wr = r_lfl_wr;
        n_fnt = r_fnt;  n_flt = r_flt;
        n_func = r_func;  n_l = r_l;  n_ol = r_ol;  n_val = r_val;
        n_fl_wr = r_fl_wr;  n_lf_wr = r_lf_wr;
        n_hf = r_hf;  n_hl = r_hl;  n_hc = r_hc;  n_hs = r_hs;
        n_n = r_n;  n_k = r_k;  n_nb = r_nb;  n_ceff = r_ceff;
        n_after = r_after;  n_cend = r_cend;
        n_res_item = r_res_item;  n_res_present = r_res_present;
        n_res_status = r_res_status;  n_res_new = r_res_new;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        it_we = 1'b0; it_re = 1'b0; it_wa = '0; it_ra = '0; it_wd = '0;
        nx_we = 1'b0; nx_re = 1'b0; nx_wa = '0; nx_ra = '0; nx_wd = '0;
        pv_we = 1'b0; pv_re = 1'b0; pv_wa = '0; pv_ra = '0; pv_wd = '0;
        fl_we = 1'b0; fl_re = 1'b0; fl_wa = '0; fl_wd = '0;
        hd_re = 1'b0; hd_ra = '0; hd_we = 1'b0; hd_wa = '0;
        sz_we = 1'b0; sz_wa = '0; sz_wd = '0;
        lf_we = 1'b0; lf_re = 1'b0; lf_wa = '0; lf_wd = '0;

        // Take the command and start the head and free chain reads.
        if (i_cmd.capture) begin
            n_func  = i_in_item.func;
            n_l     = i_in_item.list_sel;
            n_ol    = i_in_item.other_list;
            n_val   = SW'(i_in_item.item_value);
            hd_re   = 1'b1;
            hd_ra   = LW'(i_in_item.list_sel);
            fl_re   = 1'b1;
            lf_re   = 1'b1;
            n_fl_wr = r_nfl_wr[r_fnt];
            n_lf_wr = r_lfl_wr[r_flt];
        end

        // Head fields are in; decide and issue the first node reads.
        if (i_cmd.head) begin
            n_hf = r_rd_first;  n_hl = r_rd_last;  n_hc = r_rd_cur;  n_hs = r_rd_size;
            n_res_item = '0;  n_res_present = 1'b0;  n_res_status = 1'b0;  n_res_new = '0;
            if (r_func == F_CREATE) begin
                if (!r_list_used[r_flt]) begin
                    n_flt = w_next_list;
                    n_list_used[r_flt] = 1'b1;
                    sz_we = 1'b1;
                    sz_wa = r_flt;
                    sz_wd = '0;
                    n_res_new = SEL_W'(r_flt);
                end else begin
                    n_res_status = 1'b1;
                end
            end else if (!w_bad) begin
                case (r_func)
                    F_FIRST, F_LAST: begin
                        if (w_hs == '0) begin
                            n_cv[w_li] = 1'b0;
                        end else begin
                            v_c        = (r_func == F_FIRST) ? w_hf : w_hl;
                            n_hc       = v_c;
                            n_cv[w_li] = 1'b1;
                            it_re      = 1'b1;
                            it_ra      = v_c;
                        end
                    end
                    F_NEXT, F_PREV: begin
                        if (w_cv) begin
                            if (o_stat.at_edge) begin
                                n_cv[w_li] = 1'b0;
                                n_pe[w_li] = (r_func == F_NEXT);
                            end else if (r_func == F_NEXT) begin
                                nx_re = 1'b1;
                                nx_ra = w_hc;
                            end else begin
                                pv_re = 1'b1;
                                pv_ra = w_hc;
                            end
                        end
                    end
                    F_CURRENT: begin
                        it_re = w_cv;
                        it_ra = w_hc;
                    end
                    F_INS_AFTER, F_INS_BEFORE, F_APPEND, F_PREPEND: begin
                        if (!r_node_used[r_fnt]) begin
                            n_n   = r_fnt;
                            n_fnt = w_next_free;
                            n_node_used[r_fnt] = 1'b1;
                            it_we = 1'b1;
                            it_wa = r_fnt;
                            it_wd = r_val;
                            if (w_hs == '0) begin
                                n_hf = r_fnt;  n_hl = r_fnt;  n_hc = r_fnt;
                                n_cv[w_li] = 1'b1;
                                n_hs = CNT_W'(1);
                            end else begin
                                // Pick the anchor node and the side to link on.
                                if (r_func == F_APPEND ||
                                    (r_func != F_PREPEND && !w_cv && w_pe)) begin
                                    v_after = 1'b1;  v_c = w_hl;
                                end else if (r_func == F_PREPEND || !w_cv) begin
                                    v_after = 1'b0;  v_c = w_hf;
                                end else if (r_func == F_INS_AFTER) begin
                                    v_after = 1'b1;  v_c = w_hc;
                                end else begin
                                    v_after = 1'b0;  v_c = w_hc;
                                end
                                n_after = v_after;
                                n_ceff  = v_c;
                                n_cend  = v_after ? (v_c == w_hl) : (v_c == w_hf);
                                nx_re   = v_after;
                                nx_ra   = v_c;
                                pv_re   = !v_after;
                                pv_ra   = v_c;
                            end
                        end else begin
                            n_res_status = 1'b1;
                        end
                    end
                    F_REMOVE: begin
                        it_re = w_cv;  it_ra = w_hc;
                        nx_re = w_cv;  nx_ra = w_hc;
                        pv_re = w_cv;  pv_ra = w_hc;
                    end
                    F_TRIM: begin
                        it_re = (w_hs != '0);  it_ra = w_hl;
                        pv_re = (w_hs != '0);  pv_ra = w_hl;
                    end
                    F_CONCAT: begin
                        hd_re = !o_stat.cat_bad;
                        hd_ra = w_oi;
                    end
                    F_FREE: begin
                        n_n = w_hf;
                        n_k = '0;
                    end
                    default: n_res_status = 1'b0;
                endcase
            end
        end

        // Step to the neighbor and fetch its item.
        if (i_cmd.link) begin
            v_nb  = (r_func == F_NEXT) ? r_rd_next : r_rd_prev;
            n_hc  = v_nb;
            it_re = 1'b1;
            it_ra = v_nb;
        end

        if (i_cmd.item) begin
            n_res_item    = r_rd_item;
            n_res_present = 1'b1;
        end

        // Insert, first half: links of the new node.
        if (i_cmd.ins1) begin
            v_nb = r_after ? r_rd_next : r_rd_prev;
            n_nb = v_nb;
            nx_wa = r_n;
            pv_wa = r_n;
            if (r_after) begin
                nx_we = !r_cend;  nx_wd = v_nb;
                pv_we = 1'b1;     pv_wd = r_ceff;
            end else begin
                pv_we = !r_cend;  pv_wd = v_nb;
                nx_we = 1'b1;     nx_wd = r_ceff;
            end
        end

        // Insert, second half: links of the neighbors and the head.
        if (i_cmd.ins2) begin
            if (r_after) begin
                nx_we = 1'b1;  nx_wa = r_ceff;  nx_wd = r_n;
                if (r_cend) n_hl = r_n;
                else begin
                    pv_we = 1'b1;  pv_wa = r_nb;  pv_wd = r_n;
                end
            end else begin
                pv_we = 1'b1;  pv_wa = r_ceff;  pv_wd = r_n;
                if (r_cend) n_hf = r_n;
                else begin
                    nx_we = 1'b1;  nx_wa = r_nb;  nx_wd = r_n;
                end
            end
            n_hc = r_n;
            n_cv[w_li] = 1'b1;
            n_hs = r_hs + 1'b1;
        end

        // Remove the current node.
        if (i_cmd.rem) begin
            n_res_item    = r_rd_item;
            n_res_present = 1'b1;
            if (r_hs <= CNT_W'(1)) begin
                n_cv[w_li] = 1'b0;
                n_pe[w_li] = 1'b0;
            end else if (r_hc == r_hf) begin
                n_hf = r_rd_next;
                n_hc = r_rd_next;
            end else if (r_hc == r_hl) begin
                n_hl = r_rd_prev;
                n_cv[w_li] = 1'b0;
                n_pe[w_li] = 1'b1;
            end else begin
                nx_we = 1'b1;  nx_wa = r_rd_prev;  nx_wd = r_rd_next;
                pv_we = 1'b1;  pv_wa = r_rd_next;  pv_wd = r_rd_prev;
                n_hc  = r_rd_next;
            end
            n_node_used[r_hc] = 1'b0;
            n_nfl_wr[r_hc]    = 1'b1;
            fl_we = 1'b1;  fl_wa = r_hc;  fl_wd = r_fnt;
            n_fnt = r_hc;
            n_hs  = r_hs - 1'b1;
        end

        // Release the tail node.
        if (i_cmd.trim) begin
            n_res_item    = r_rd_item;
            n_res_present = 1'b1;
            if (r_hs == CNT_W'(1)) begin
                n_cv[w_li] = 1'b0;
                n_pe[w_li] = 1'b0;
            end else begin
                n_hl = r_rd_prev;
                n_hc = r_rd_prev;
                n_cv[w_li] = 1'b1;
            end
            n_node_used[r_hl] = 1'b0;
            n_nfl_wr[r_hl]    = 1'b1;
            fl_we = 1'b1;  fl_wa = r_hl;  fl_wd = r_fnt;
            n_fnt = r_hl;
            n_hs  = r_hs - 1'b1;
        end

        // Splice the other list onto the tail, then release its head.
        if (i_cmd.cat) begin
            if (r_hs == '0) begin
                n_hf = r_rd_first;
                n_hl = r_rd_last;
            end else if (r_rd_size != '0) begin
                nx_we = 1'b1;  nx_wa = r_hl;        nx_wd = r_rd_first;
                pv_we = 1'b1;  pv_wa = r_rd_first;  pv_wd = r_hl;
                n_hl  = r_rd_last;
            end
            n_hs  = r_hs + r_rd_size;
            sz_we = 1'b1;  sz_wa = w_oi;  sz_wd = '0;
            n_cv[w_oi] = 1'b0;
            n_pe[w_oi] = 1'b0;
            n_list_used[w_oi] = 1'b0;
            n_lfl_wr[w_oi]    = 1'b1;
            lf_we = 1'b1;  lf_wa = w_oi;  lf_wd = r_flt;
            n_flt = w_oi;
        end

        // Free walk: fetch the next node.
        if (i_cmd.fread) begin
            it_re = 1'b1;  it_ra = r_n;
            nx_re = 1'b1;  nx_ra = r_n;
        end

        // Free walk: hand out one item and release its node; release the head at the end.
        if (i_cmd.femit) begin
            n_out_valid        = 1'b1;
            n_out.status       = 1'b0;
            n_out.new_list     = '0;
            n_out.count_out    = '0;
            if (r_hs == '0) begin
                n_out.item_out     = '0;
                n_out.item_present = 1'b0;
                n_out.last_of_run  = 1'b1;
            end else begin
                n_out.item_out     = DATA_W'(r_rd_item);
                n_out.item_present = 1'b1;
                n_out.last_of_run  = o_stat.free_last;
                n_node_used[r_n]   = 1'b0;
                n_nfl_wr[r_n]      = 1'b1;
                fl_we = 1'b1;  fl_wa = r_n;  fl_wd = r_fnt;
                n_fnt = r_n;
                n_n   = r_rd_next;
                n_k   = r_k + 1'b1;
            end
            if (r_hs == '0 || o_stat.free_last) begin
                sz_we = 1'b1;  sz_wa = w_li;  sz_wd = '0;
                n_cv[w_li] = 1'b0;
                n_pe[w_li] = 1'b0;
                n_list_used[w_li] = 1'b0;
                n_lfl_wr[w_li]    = 1'b1;
                lf_we = 1'b1;  lf_wa = w_li;  lf_wd = r_flt;
                n_flt = w_li;
            end
        end

        // Write the head fields back.
        if (i_cmd.wb) begin
            hd_we = 1'b1;  hd_wa = w_li;
            sz_we = 1'b1;  sz_wa = w_li;  sz_wd = r_hs;
        end

        // Single result of every command but free.
        if (i_cmd.resp) begin
            n_out_valid        = 1'b1;
            n_out.item_out     = DATA_W'(r_res_item);
            n_out.item_present = r_res_present;
            n_out.status       = r_res_status;
            n_out.new_list     = r_res_new;
            n_out.count_out    = (r_func != F_CREATE && w_l_ok && r_list_used[w_li]) ?
                                 r_hs : '0;
            n_out.last_of_run  = 1'b1;
        end
    end

    // Node memories.
    always_ff @(posedge i_clk) begin
        if (it_we) m_item[it_wa] <= it_wd;
        if (it_re) r_rd_item <= m_item[it_ra];
        if (nx_we) m_next[nx_wa] <= nx_wd;
        if (nx_re) r_rd_next <= m_next[nx_ra];
        if (pv_we) m_prev[pv_wa] <= pv_wd;
        if (pv_re) r_rd_prev <= m_prev[pv_ra];
        if (fl_we) m_flink[fl_wa] <= fl_wd;
        if (fl_re) r_rd_flink <= m_flink[r_fnt];
    end

    // Head memories.
    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            m_first[hd_wa] <= r_hf;
            m_last[hd_wa]  <= r_hl;
            m_cur[hd_wa]   <= r_hc;
        end
        if (sz_we) m_size[sz_wa] <= sz_wd;
        if (hd_re) begin
            r_rd_first <= m_first[hd_ra];
            r_rd_last  <= m_last[hd_ra];
            r_rd_cur   <= m_cur[hd_ra];
            r_rd_size  <= m_size[hd_ra];
        end
        if (lf_we) m_lfl[lf_wa] <= lf_wd;
        if (lf_re) r_rd_lfl <= m_lfl[r_flt];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_used <= '0;
            r_nfl_wr    <= '0;
            r_list_used <= '0;
            r_cv        <= '0;
            r_pe        <= '0;
            r_lfl_wr    <= '0;
            r_fnt       <= '0;
            r_flt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_node_used <= n_node_used;
            r_nfl_wr    <= n_nfl_wr;
            r_list_used <= n_list_used;
            r_cv        <= n_cv;
            r_pe        <= n_pe;
            r_lfl_wr    <= n_lfl_wr;
            r_fnt       <= n_fnt;
            r_flt       <= n_flt;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_func <= n_func;  r_l <= n_l;  r_ol <= n_ol;  r_val <= n_val;
        r_fl_wr <= n_fl_wr;  r_lf_wr <= n_lf_wr;
        r_hf <= n_hf;  r_hl <= n_hl;  r_hc <= n_hc;  r_hs <= n_hs;
        r_n <= n_n;  r_k <= n_k;  r_nb <= n_nb;  r_ceff <= n_ceff;
        r_after <= n_after;  r_cend <= n_cend;
        r_res_item <= n_res_item;  r_res_present <= n_res_present;
        r_res_status <= n_res_status;  r_res_new <= n_res_new;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

>>> hw/rtl/pooled_linked_list_manager_unit.sv
`timescale 1ns / 1ps
// Top level of the pooled linked list manager: controller plus datapath.
// Depends on pllm_pkg, pllm_in_if, pllm_out_if, pllm_ctrl and pllm_dpath.
//
//   Channel   Dir   Payload                                             Transfer
//   i_in      in    func, list_sel, other_list, item_value              valid & ready
//   o_out     out   item_out, item_present, status, new_list,           valid & ready
//                   count_out, last_of_run
//
// One command at a time. Each command runs through a chain of steps set by the registered
// node and head memory reads and the head write-back. Free reads one node and hands out one
// result per released item, and gives a single result for an empty list.
// Reset is synchronous and clears the pools at once; the block is ready right after.
// A stalled result holds the block in its next result or free emit step until that transfer.
module pooled_linked_list_manager_unit #(
    parameter int NODE_COUNT = 64,
    parameter int HEAD_COUNT = 16,
    parameter int ITEM_WIDTH = 32
) (
    input logic         i_clk,
    input logic         i_rst_n,
    pllm_in_if.sink     i_in,
    pllm_out_if.source  o_out
);
    import pllm_pkg::*;

    t_cmd      w_cmd;
    t_stat     w_stat;
    t_in_item  w_in_item;
    t_out_item w_out_item;
    logic      w_in_ready;
    logic      w_out_valid;

    // Command payload into one struct.
    always_comb begin
        w_in_item.func       = i_in.func;
        w_in_item.list_sel   = i_in.list_sel;
        w_in_item.other_list = i_in.other_list;
        w_in_item.item_value = i_in.item_value;
    end

    assign i_in.ready = w_in_ready;

    pllm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pllm_dpath #(
        .NODE_COUNT (NODE_COUNT),
        .HEAD_COUNT (HEAD_COUNT),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_item   (w_in_item),
        .i_out_ready (o_out.ready),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

    // Result register onto the channel.
    assign o_out.valid        = w_out_valid;
    assign o_out.item_out     = w_out_item.item_out;
    assign o_out.item_present = w_out_item.item_present;
    assign o_out.status       = w_out_item.status;
    assign o_out.new_list     = w_out_item.new_list;
    assign o_out.count_out    = w_out_item.count_out;
    assign o_out.last_of_run  = w_out_item.last_of_run;

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the pooled linked list manager: directed and random commands,
// with results checked against a behavioral model of both pools and all lists.
// Depends on pllm_pkg, pllm_in_if, pllm_out_if and pooled_linked_list_manager_unit.
module tb;
    import pllm_pkg::*;

    localparam int NODES    = 64;
    localparam int HEADS    = 16;
    localparam int WD_LIMIT = 4000;
    localparam int QUIET_AT = 40;
    localparam logic [FUNC_W-1:0] F_UNUSED = 4'd15;

    logic i_clk;
    logic i_rst_n;

    pllm_in_if  cmd_if ();
    pllm_out_if res_if ();

    pooled_linked_list_manager_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if.sink),
        .o_out   (res_if.source)
    );

    // Model state of the pools and list heads.
    logic [DATA_W-1:0] nd_item  [NODES];
    logic [5:0]        nd_next  [NODES];
    logic [5:0]        nd_prev  [NODES];
    logic [5:0]        nd_flink [NODES];
    logic              nd_used  [NODES];
    logic [5:0]        ls_first [HEADS];
    logic [5:0]        ls_last  [HEADS];
    logic [5:0]        cur_node [HEADS];
    logic              cur_ok   [HEADS];
    logic              cur_past [HEADS];
    logic [CNT_W-1:0]  ls_size  [HEADS];
    logic              ls_used  [HEADS];
    logic [3:0]        ls_flink [HEADS];
    logic [5:0]        node_top;
    logic [3:0]        head_top;

    t_in_item  cmd_q [$];
    t_out_item expected_q [$];

    int  errors;
    int  gap_left;
    int  stall_left;
    int  idle_cycles;
    logic quiet;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic void model_reset();
        for (int i = 0; i < NODES; i++) begin
            nd_item[i]  = '0;
            nd_next[i]  = '0;
            nd_prev[i]  = '0;
            nd_used[i]  = 1'b0;
            nd_flink[i] = 6'((i + 1) % NODES);
        end
        for (int i = 0; i < HEADS; i++) begin
            ls_first[i] = '0;
            ls_last[i]  = '0;
            cur_node[i] = '0;
            cur_ok[i]   = 1'b0;
            cur_past[i] = 1'b0;
            ls_size[i]  = '0;
            ls_used[i]  = 1'b0;
            ls_flink[i] = 4'((i + 1) % HEADS);
        end
        node_top = '0;
        head_top = '0;
    endfunction

    function automatic void expect_result(input logic [DATA_W-1:0] item, input logic present,
                                          input logic st, input logic [3:0] nl,
                                          input logic [CNT_W-1:0] cnt, input logic last);
        t_out_item r;
        r.item_out     = item;
        r.item_present = present;
        r.status       = st;
        r.new_list     = nl;
        r.count_out    = cnt;
        r.last_of_run  = last;
        expected_q.push_back(r);
    endfunction

    function automatic void drop_node(input logic [5:0] n);
        nd_used[n]  = 1'b0;
        nd_flink[n] = node_top;
        node_top    = n;
    endfunction

    function automatic void drop_head(input logic [3:0] l);
        ls_size[l]  = '0;
        cur_ok[l]   = 1'b0;
        cur_past[l] = 1'b0;
        ls_used[l]  = 1'b0;
        ls_flink[l] = head_top;
        head_top    = l;
    endfunction

    function automatic void link_after(input logic [3:0] l, input logic [5:0] c,
                                       input logic [5:0] n);
        if (c == ls_last[l]) begin
            ls_last[l] = n;
        end else begin
            nd_next[n]          = nd_next[c];
            nd_prev[nd_next[c]] = n;
        end
        nd_prev[n] = c;
        nd_next[c] = n;
    endfunction

    function automatic void link_before(input logic [3:0] l, input logic [5:0] c,
                                        input logic [5:0] n);
        if (c == ls_first[l]) begin
            ls_first[l] = n;
        end else begin
            nd_prev[n]          = nd_prev[c];
            nd_next[nd_prev[c]] = n;
        end
        nd_next[n] = c;
        nd_prev[c] = n;
    endfunction

    // Applies one accepted command to the model and queues the results it causes.
    function automatic void apply_command(input t_in_item it);
        logic [3:0]        l;
        logic [3:0]        ol;
        logic [5:0]        c;
        logic [5:0]        n;
        logic [5:0]        nx;
        logic [DATA_W-1:0] item;
        logic              present;
        logic              st;
        int                cnt;
        l       = it.list_sel;
        ol      = it.other_list;
        item    = '0;
        present = 1'b0;
        st      = 1'b0;
        if (it.func == F_CREATE) begin
            if (ls_used[head_top]) begin
                expect_result('0, 1'b0, 1'b1, '0, '0, 1'b1);
            end else begin
                expect_result('0, 1'b0, 1'b0, head_top, '0, 1'b1);
                ls_used[head_top] = 1'b1;
                head_top = ls_flink[head_top];
            end
            return;
        end
        if (it.func == F_UNUSED || !ls_used[l]) begin
            expect_result('0, 1'b0, 1'b0, '0, ls_size[l], 1'b1);
            return;
        end
        c = cur_node[l];
        case (it.func)
            F_FIRST, F_LAST: begin
                if (ls_size[l] == 0) begin
                    cur_ok[l] = 1'b0;
                end else begin
                    c           = (it.func == F_FIRST) ? ls_first[l] : ls_last[l];
                    cur_node[l] = c;
                    cur_ok[l]   = 1'b1;
                    item        = nd_item[c];
                    present     = 1'b1;
                end
            end
            F_NEXT, F_PREV: begin
                if (cur_ok[l]) begin
                    if ((it.func == F_NEXT) ? (c == ls_last[l]) : (c == ls_first[l])) begin
                        cur_ok[l]   = 1'b0;
                        cur_past[l] = (it.func == F_NEXT);
                    end else begin
                        c           = (it.func == F_NEXT) ? nd_next[c] : nd_prev[c];
                        cur_node[l] = c;
                        item        = nd_item[c];
                        present     = 1'b1;
                    end
                end
            end
            F_CURRENT: begin
                if (cur_ok[l]) begin
                    item    = nd_item[c];
                    present = 1'b1;
                end
            end
            F_INS_AFTER, F_INS_BEFORE, F_APPEND, F_PREPEND: begin
                n = node_top;
                if (nd_used[n]) begin
                    st = 1'b1;
                end else begin
                    node_top   = nd_flink[n];
                    nd_used[n] = 1'b1;
                    nd_item[n] = it.item_value;
                    if (ls_size[l] == 0) begin
                        ls_first[l] = n;
                        ls_last[l]  = n;
                    end else if (it.func == F_APPEND ||
                                 (it.func != F_PREPEND && !cur_ok[l] && cur_past[l])) begin
                        link_after(l, ls_last[l], n);
                    end else if (it.func == F_PREPEND || !cur_ok[l]) begin
                        link_before(l, ls_first[l], n);
                    end else if (it.func == F_INS_AFTER) begin
                        link_after(l, c, n);
                    end else begin
                        link_before(l, c, n);
                    end
                    cur_node[l] = n;
                    cur_ok[l]   = 1'b1;
                    ls_size[l]  = ls_size[l] + 1'b1;
                end
            end
            F_REMOVE: begin
                if (cur_ok[l]) begin
                    item    = nd_item[c];
                    present = 1'b1;
                    if (ls_size[l] <= 1) begin
                        cur_ok[l]   = 1'b0;
                        cur_past[l] = 1'b0;
                    end else if (c == ls_first[l]) begin
                        ls_first[l] = nd_next[c];
                        cur_node[l] = nd_next[c];
                    end else if (c == ls_last[l]) begin
                        ls_last[l]  = nd_prev[c];
                        cur_ok[l]   = 1'b0;
                        cur_past[l] = 1'b1;
                    end else begin
                        nd_next[nd_prev[c]] = nd_next[c];
                        nd_prev[nd_next[c]] = nd_prev[c];
                        cur_node[l]         = nd_next[c];
                    end
                    drop_node(c);
                    ls_size[l] = ls_size[l] - 1'b1;
                end
            end
            F_TRIM: begin
                if (ls_size[l] != 0) begin
                    n       = ls_last[l];
                    item    = nd_item[n];
                    present = 1'b1;
                    if (ls_size[l] == 1) begin
                        cur_ok[l]   = 1'b0;
                        cur_past[l] = 1'b0;
                    end else begin
                        ls_last[l]  = nd_prev[n];
                        cur_node[l] = nd_prev[n];
                        cur_ok[l]   = 1'b1;
                    end
                    drop_node(n);
                    ls_size[l] = ls_size[l] - 1'b1;
                end
            end
            F_CONCAT: begin
                if (ol != l && ls_used[ol]) begin
                    if (ls_size[l] == 0) begin
                        ls_first[l] = ls_first[ol];
                        ls_last[l]  = ls_last[ol];
                    end else if (ls_size[ol] != 0) begin
                        nd_next[ls_last[l]]  = ls_first[ol];
                        nd_prev[ls_first[ol]] = ls_last[l];
                        ls_last[l]           = ls_last[ol];
                    end
                    ls_size[l] = ls_size[l] + ls_size[ol];
                    drop_head(ol);
                end
            end
            F_FREE: begin
                cnt = int'(ls_size[l]);
                n   = ls_first[l];
                if (cnt == 0) expect_result('0, 1'b0, 1'b0, '0, '0, 1'b1);
                if (cnt > NODES) cnt = NODES;
                for (int k = 0; k < cnt; k++) begin
                    nx = nd_next[n];
                    expect_result(nd_item[n], 1'b1, 1'b0, '0, '0, k + 1 == cnt);
                    drop_node(n);
                    n = nx;
                end
                drop_head(l);
                return;
            end
            default: ;
        endcase
        expect_result(item, present, st, '0, ls_size[l], 1'b1);
    endfunction

    function automatic t_in_item make_cmd(input logic [FUNC_W-1:0] f, input logic [3:0] l,
                                          input logic [3:0] ol, input logic [31:0] v);
        t_in_item it;
        it.func       = f;
        it.list_sel   = l;
        it.other_list = ol;
        it.item_value = v;
        return it;
    endfunction

    // Random command; the fill flag favors creates and inserts so that both pools run dry.
    function automatic t_in_item random_cmd(input logic fill);
        int               p;
        logic [FUNC_W-1:0] f;
        logic [3:0]        l;
        logic [3:0]        ol;
        p  = $urandom_range(0, 99);
        l  = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
        ol = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
        if (fill) begin
            if (p < 12)      f = F_CREATE;
            else if (p < 72) f = 4'($urandom_range(F_INS_AFTER, F_PREPEND));
            else if (p < 95) f = 4'($urandom_range(F_COUNT, F_CURRENT));
            else             f = 4'($urandom_range(F_REMOVE, F_UNUSED));
        end else begin
            if (p < 8)       f = F_CREATE;
            else if (p < 40) f = 4'($urandom_range(F_INS_AFTER, F_PREPEND));
            else if (p < 70) f = 4'($urandom_range(F_COUNT, F_CURRENT));
            else if (p < 97) f = 4'($urandom_range(F_REMOVE, F_FREE));
            else             f = F_UNUSED;
        end
        return make_cmd(f, l, ol, $urandom());
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Command driver: holds each command until its transfer, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid      <= 1'b0;
            cmd_if.func       <= '0;
            cmd_if.list_sel   <= '0;
            cmd_if.other_list <= '0;
            cmd_if.item_value <= '0;
            gap_left          <= 0;
        end else if (!cmd_if.valid || cmd_if.ready) begin
            if (gap_left > 0) begin
                cmd_if.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (cmd_q.size() == 0) begin
                cmd_if.valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                cmd_if.valid <= 1'b0;
                gap_left     <= $urandom_range(0, 9);
            end else begin
                t_in_item it;
                it = cmd_q.pop_front();
                cmd_if.valid      <= 1'b1;
                cmd_if.func       <= it.func;
                cmd_if.list_sel   <= it.list_sel;
                cmd_if.other_list <= it.other_list;
                cmd_if.item_value <= it.item_value;
            end
        end
    end

    // Result stalls in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b1;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 9);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Monitor: checks each result transfer, then models each command transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result", res_if.item_out, '0);
                end else begin
                    t_out_item e;
                    e = expected_q.pop_front();
                    if (res_if.item_out !== e.item_out)
                        report("item_out", res_if.item_out, e.item_out);
                    if (res_if.item_present !== e.item_present)
                        report("item_present", 32'(res_if.item_present), 32'(e.item_present));
                    if (res_if.status !== e.status)
                        report("status", 32'(res_if.status), 32'(e.status));
                    if (res_if.new_list !== e.new_list)
                        report("new_list", 32'(res_if.new_list), 32'(e.new_list));
                    if (res_if.count_out !== e.count_out)
                        report("count_out", 32'(res_if.count_out), 32'(e.count_out));
                    if (res_if.last_of_run !== e.last_of_run)
                        report("last_of_run", 32'(res_if.last_of_run), 32'(e.last_of_run));
                end
            end
            if (cmd_if.valid && cmd_if.ready)
                apply_command(make_cmd(cmd_if.func, cmd_if.list_sel, cmd_if.other_list,
                                       cmd_if.item_value));
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        errors  = 0;
        quiet   = 1'b0;
        i_rst_n = 1'b0;
        model_reset();

        // Directed walk through every command and the corner cases.
        cmd_q.push_back(make_cmd(F_CREATE, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_CREATE, 4'd15, 4'd15, '1));
        cmd_q.push_back(make_cmd(F_COUNT, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_FIRST, 4'd0, 4'd0, '0));      // empty list
        cmd_q.push_back(make_cmd(F_TRIM, 4'd0, 4'd0, '0));       // empty list
        cmd_q.push_back(make_cmd(F_NEXT, 4'd0, 4'd0, '0));       // no current item
        cmd_q.push_back(make_cmd(F_APPEND, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_APPEND, 4'd0, 4'd0, '1));
        cmd_q.push_back(make_cmd(F_PREPEND, 4'd0, 4'd0, 32'h5a5a_a5a5));
        cmd_q.push_back(make_cmd(F_FIRST, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_PREV, 4'd0, 4'd0, '0));       // moves before the start
        cmd_q.push_back(make_cmd(F_INS_BEFORE, 4'd0, 4'd0, 32'h1234_5678));
        cmd_q.push_back(make_cmd(F_LAST, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_NEXT, 4'd0, 4'd0, '0));       // moves past the end
        cmd_q.push_back(make_cmd(F_INS_AFTER, 4'd0, 4'd0, 32'h8000_0001));
        cmd_q.push_back(make_cmd(F_CURRENT, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_REMOVE, 4'd0, 4'd0, '0));     // tail removed
        cmd_q.push_back(make_cmd(F_APPEND, 4'd1, 4'd0, 32'h0f0f_f0f0));
        cmd_q.push_back(make_cmd(F_TRIM, 4'd1, 4'd0, '0));       // one-item list
        cmd_q.push_back(make_cmd(F_CONCAT, 4'd0, 4'd0, '0));     // source equals destination
        cmd_q.push_back(make_cmd(F_CONCAT, 4'd0, 4'd1, '0));
        cmd_q.push_back(make_cmd(F_FREE, 4'd1, 4'd0, '0));       // head no longer in use
        cmd_q.push_back(make_cmd(F_UNUSED, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_FREE, 4'd0, 4'd0, '0));
        cmd_q.push_back(make_cmd(F_COUNT, 4'd7, 4'd0, '0));

        // Random part: a fill phase that drains the pools, then a general mix.
        for (int i = 0; i < 100; i++) cmd_q.push_back(random_cmd(1'b1));
        for (int i = 0; i < 150; i++) cmd_q.push_back(random_cmd(1'b0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() >= QUIET_AT) @(posedge i_clk);
        quiet = 1'b1;
        while (cmd_q.size() != 0 || cmd_if.valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
